>>> hdl/record_block_deframer_defines.svh
// Assertion macros shared by the record block deframer RTL.
`ifndef RECORD_BLOCK_DEFRAMER_DEFINES_SVH
`define RECORD_BLOCK_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition and consequence in the same cycle.
`define RBD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("record_block_deframer: check failed");

// Consequence in the cycle after the condition.
`define RBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("record_block_deframer: check failed");

`else

`define RBD_ASSERT_SAME(lbl, ante, cons)
`define RBD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/rbd_pkg.sv
// Types, codes and constants of the record block deframer.
`default_nettype none

package rbd_pkg;

  // Configuration register indexes
  localparam logic CFG_NUMERIC_ELEMS = 1'b0;
  localparam logic CFG_TEXT_ELEMS    = 1'b1;

  localparam logic [9:0] NUMERIC_ELEMS_RESET = 10'd1000;
  localparam logic [9:0] TEXT_ELEMS_RESET    = 10'd105;

  // Type names as they appear in the header, first character in the top byte
  localparam logic [31:0] NAME_INTE = 32'h494E5445;
  localparam logic [31:0] NAME_REAL = 32'h5245414C;
  localparam logic [31:0] NAME_LOGI = 32'h4C4F4749;
  localparam logic [31:0] NAME_DOUB = 32'h444F5542;
  localparam logic [31:0] NAME_CHAR = 32'h43484152;
  localparam logic [31:0] NAME_MESS = 32'h4D455353;
  localparam logic [15:0] NAME_C0   = 16'h4330;
  localparam logic [7:0]  ASCII_ZERO = 8'h30;
  localparam logic [7:0]  ASCII_NINE = 8'h39;

  // Type codes
  localparam logic [2:0] TY_INTE = 3'd0;
  localparam logic [2:0] TY_REAL = 3'd1;
  localparam logic [2:0] TY_LOGI = 3'd2;
  localparam logic [2:0] TY_DOUB = 3'd3;
  localparam logic [2:0] TY_CHAR = 3'd4;
  localparam logic [2:0] TY_MESS = 3'd5;

  localparam logic [6:0] SIZE_WORD   = 7'd4;
  localparam logic [6:0] SIZE_DOUBLE = 7'd8;
  localparam logic [3:0] CHUNK_MAX   = 4'd8;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_CHUNK     = 2'd1,
    KIND_BAD_TYPE  = 2'd2,
    KIND_TRUNCATED = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] keyword;
    logic [31:0] element_count;
    logic [2:0]  type_code;
    logic [6:0]  element_bytes;
    logic [63:0] chunk_value;
    logic [3:0]  chunk_bytes;
    logic        element_end;
    logic        block_end;
  } out_word_t;

  // Decoded block type
  typedef struct packed {
    logic       known;
    logic [2:0] code;
    logic [6:0] size;
  } type_info_t;

endpackage

`default_nettype wire

>>> hdl/rbd_type_decode.sv
// Decoder of the four-character block type into type code and element size.
`default_nettype none

module rbd_type_decode (
  input  wire logic [31:0]       type_word,
  output rbd_pkg::type_info_t    info
);

  logic [7:0] digit_hi;
  logic [7:0] digit_lo;
  logic [6:0] text_size;
  logic       digits_ok;

  assign digit_hi = type_word[15:8];
  assign digit_lo = type_word[7:0];

  // Two decimal digits after C0 give the character length.
  always_comb begin
    digits_ok = (digit_hi inside {[rbd_pkg::ASCII_ZERO:rbd_pkg::ASCII_NINE]}) &&
                (digit_lo inside {[rbd_pkg::ASCII_ZERO:rbd_pkg::ASCII_NINE]});
    text_size = (7'(digit_hi[3:0]) * 7'd10) + 7'(digit_lo[3:0]);
  end

  // Match the fixed names first, then the sized character form.
  always_comb begin
    info = '0;
    case (type_word)
      rbd_pkg::NAME_INTE: info = '{1'b1, rbd_pkg::TY_INTE, rbd_pkg::SIZE_WORD};
      rbd_pkg::NAME_REAL: info = '{1'b1, rbd_pkg::TY_REAL, rbd_pkg::SIZE_WORD};
      rbd_pkg::NAME_LOGI: info = '{1'b1, rbd_pkg::TY_LOGI, rbd_pkg::SIZE_WORD};
      rbd_pkg::NAME_DOUB: info = '{1'b1, rbd_pkg::TY_DOUB, rbd_pkg::SIZE_DOUBLE};
      rbd_pkg::NAME_CHAR: info = '{1'b1, rbd_pkg::TY_CHAR, rbd_pkg::SIZE_DOUBLE};
      rbd_pkg::NAME_MESS: info = '{1'b1, rbd_pkg::TY_MESS, rbd_pkg::SIZE_DOUBLE};
      default: begin
        if ((type_word[31:16] == rbd_pkg::NAME_C0) && digits_ok && (text_size != 7'd0)) begin
          info = '{1'b1, rbd_pkg::TY_CHAR, text_size};
        end
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/record_block_deframer.sv
// Record block deframer: parses a keyworded unformatted file one byte per word.
// Input channel in_*: one file byte and an end-of-file flag per word. The
// block accepts one word in every cycle unless in_stall is high.
// Result channel out_*: header, element chunk, bad type and truncated header
// results. A result caused by an accepted byte is registered in the output register, or
// in the skid register while the receiver stalls; bytes that cause no result give no word.
// Throughput is one byte per cycle while in_stall is low, set by the single per-byte update
// of the counters and shift registers between the input and the output register.
// A skid register behind the output register takes one more result while the
// receiver stalls; in_stall rises only while that skid register is occupied.
// Configuration port cfg_*: index 0 sets elements per numeric record, index 1
// elements per text record; cfg_ready is always high and a new value is used
// from the next data record head.
// Reset (rst_n low, synchronous) returns the parser to the lead marker of a new
// file, sets the registers to 1000 and 105 and empties the output stages.
// A byte flagged end_of_file returns the parser to that same start state.
`default_nettype none

`include "record_block_deframer_defines.svh"

module record_block_deframer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rbd_pkg::in_word_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rbd_pkg::out_word_t       out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [9:0]          cfg_data
);

  typedef enum logic [6:0] {
    PH_LEAD  = 7'b0000001,
    PH_HEAD  = 7'b0000010,
    PH_HTAIL = 7'b0000100,
    PH_RHEAD = 7'b0001000,
    PH_DATA  = 7'b0010000,
    PH_RTAIL = 7'b0100000,
    PH_WAIT  = 7'b1000000
  } phase_t;

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [4:0]  pbc_r, pbc_nxt;
  logic [63:0] keyword_r, keyword_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] type_word_r, type_word_nxt;
  logic [31:0] block_left_r, block_left_nxt;
  logic [9:0]  record_left_r, record_left_nxt;
  logic [6:0]  elem_byte_r, elem_byte_nxt;
  logic [6:0]  elem_size_r, elem_size_nxt;
  logic [2:0]  cur_type_r, cur_type_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  fill_r, fill_nxt;

  // Configuration registers
  logic [9:0]  numeric_elems_r;
  logic [9:0]  text_elems_r;

  // Output register and skid register
  logic                out_valid_r, out_valid_nxt;
  rbd_pkg::out_word_t  out_word_r, out_word_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  rbd_pkg::out_word_t  skid_word_r, skid_word_nxt;

  logic                take_in;
  logic                out_fire;
  logic                res_valid;
  rbd_pkg::out_word_t  res;
  rbd_pkg::type_info_t type_info;
  logic [31:0]         type_word_full;

  // Data phase helpers
  logic [63:0] acc_new;
  logic [3:0]  fill_new;
  logic [6:0]  elem_byte_new;
  logic        elem_done;
  logic        block_done;
  logic        emit;
  logic [31:0] block_dec;
  logic [9:0]  record_dec;
  logic [9:0]  rec_limit;
  logic [9:0]  rec_limit_eff;

  assign take_in   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;
  assign cfg_ready = 1'b1;

  // The type word as it stands once the current header byte is shifted in.
  assign type_word_full = {type_word_r[23:0], in_data.data_byte};

  rbd_type_decode u_type_decode (
    .type_word (type_word_full),
    .info      (type_info)
  );

  // Element and chunk bookkeeping for a data byte.
  always_comb begin
    acc_new       = {acc_r[55:0], in_data.data_byte};
    fill_new      = fill_r + 4'd1;
    elem_byte_new = elem_byte_r + 7'd1;
    elem_done     = elem_byte_new >= elem_size_r;
    block_dec     = (block_left_r != 32'd0) ? (block_left_r - 32'd1) : block_left_r;
    record_dec    = (record_left_r != 10'd0) ? (record_left_r - 10'd1) : record_left_r;
    block_done    = elem_done && (block_dec == 32'd0);
    if (cur_type_r == rbd_pkg::TY_LOGI) begin
      emit = elem_done;
    end else begin
      emit = elem_done || (fill_new >= rbd_pkg::CHUNK_MAX);
    end
    rec_limit     = (cur_type_r >= rbd_pkg::TY_CHAR) ? text_elems_r : numeric_elems_r;
    rec_limit_eff = (rec_limit == 10'd0) ? 10'd1 : rec_limit;
  end

  // Per-byte parser step.
  always_comb begin
    phase_nxt       = phase_r;
    pbc_nxt         = pbc_r;
    keyword_nxt     = keyword_r;
    count_nxt       = count_r;
    type_word_nxt   = type_word_r;
    block_left_nxt  = block_left_r;
    record_left_nxt = record_left_r;
    elem_byte_nxt   = elem_byte_r;
    elem_size_nxt   = elem_size_r;
    cur_type_nxt    = cur_type_r;
    acc_nxt         = acc_r;
    fill_nxt        = fill_r;
    res_valid       = 1'b0;
    res             = '0;

    if (take_in) begin
      case (phase_r)
        PH_LEAD: begin
          if (pbc_r == 5'd3) begin
            phase_nxt = PH_HEAD;
            pbc_nxt   = 5'd0;
          end else begin
            pbc_nxt = pbc_r + 5'd1;
          end
        end

        PH_HEAD: begin
          if (pbc_r < 5'd8) begin
            keyword_nxt = {keyword_r[55:0], in_data.data_byte};
          end else if (pbc_r < 5'd12) begin
            count_nxt = {count_r[23:0], in_data.data_byte};
          end else begin
            type_word_nxt = type_word_full;
          end
          if (pbc_r == 5'd15) begin
            pbc_nxt   = 5'd0;
            res_valid = 1'b1;
            res.keyword       = keyword_r;
            res.element_count = count_r;
            if (type_info.known) begin
              cur_type_nxt      = type_info.code;
              elem_size_nxt     = type_info.size;
              block_left_nxt    = count_r;
              res.kind          = rbd_pkg::KIND_HEADER;
              res.type_code     = type_info.code;
              res.element_bytes = type_info.size;
              phase_nxt         = PH_HTAIL;
            end else begin
              res.kind  = rbd_pkg::KIND_BAD_TYPE;
              phase_nxt = PH_WAIT;
            end
          end else begin
            pbc_nxt = pbc_r + 5'd1;
            if (in_data.end_of_file) begin
              res_valid = 1'b1;
              res.kind  = rbd_pkg::KIND_TRUNCATED;
            end
          end
        end

        PH_HTAIL, PH_RTAIL: begin
          if (pbc_r == 5'd3) begin
            pbc_nxt   = 5'd0;
            phase_nxt = (block_left_r == 32'd0) ? PH_LEAD : PH_RHEAD;
          end else begin
            pbc_nxt = pbc_r + 5'd1;
          end
        end

        PH_RHEAD: begin
          if (pbc_r == 5'd3) begin
            pbc_nxt         = 5'd0;
            record_left_nxt = (block_left_r < 32'(rec_limit_eff)) ? block_left_r[9:0]
                                                                   : rec_limit_eff;
            elem_byte_nxt   = 7'd0;
            acc_nxt         = 64'd0;
            fill_nxt        = 4'd0;
            phase_nxt       = PH_DATA;
          end else begin
            pbc_nxt = pbc_r + 5'd1;
          end
        end

        PH_DATA: begin
          if (elem_done) begin
            elem_byte_nxt   = 7'd0;
            block_left_nxt  = block_dec;
            record_left_nxt = record_dec;
            if ((record_dec == 10'd0) || block_done) begin
              phase_nxt = PH_RTAIL;
              pbc_nxt   = 5'd0;
            end
          end else begin
            elem_byte_nxt = elem_byte_new;
          end
          if (emit) begin
            res_valid         = 1'b1;
            res.kind          = rbd_pkg::KIND_CHUNK;
            res.keyword       = keyword_r;
            res.element_count = count_r;
            res.type_code     = cur_type_r;
            res.element_bytes = elem_size_r;
            if (cur_type_r == rbd_pkg::TY_LOGI) begin
              res.chunk_value = {63'd0, (acc_new != 64'd0)};
            end else begin
              res.chunk_value = acc_new;
            end
            res.chunk_bytes = fill_new;
            res.element_end = elem_done;
            res.block_end   = block_done;
            acc_nxt         = 64'd0;
            fill_nxt        = 4'd0;
          end else begin
            acc_nxt  = acc_new;
            fill_nxt = fill_new;
          end
        end

        PH_WAIT: begin
          phase_nxt = PH_WAIT;
        end

        default: begin
          phase_nxt = PH_LEAD;
        end
      endcase

      // The last byte of a file leaves the parser ready for a new file.
      if (in_data.end_of_file) begin
        phase_nxt       = PH_LEAD;
        pbc_nxt         = 5'd0;
        keyword_nxt     = 64'd0;
        count_nxt       = 32'd0;
        type_word_nxt   = 32'd0;
        block_left_nxt  = 32'd0;
        record_left_nxt = 10'd0;
        elem_byte_nxt   = 7'd0;
        elem_size_nxt   = 7'd0;
        cur_type_nxt    = 3'd0;
        acc_nxt         = 64'd0;
        fill_nxt        = 4'd0;
      end
    end
  end

  // Output register with a skid register behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    skid_valid_nxt = skid_valid_r;
    skid_word_nxt  = skid_word_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_word_nxt   = skid_word_r;
        skid_valid_nxt = 1'b0;
      end else if (res_valid) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_word_nxt  = res;
    end
  end

  // Parser and handshake registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LEAD;
      pbc_r         <= 5'd0;
      keyword_r     <= 64'd0;
      count_r       <= 32'd0;
      type_word_r   <= 32'd0;
      block_left_r  <= 32'd0;
      record_left_r <= 10'd0;
      elem_byte_r   <= 7'd0;
      elem_size_r   <= 7'd0;
      cur_type_r    <= 3'd0;
      acc_r         <= 64'd0;
      fill_r        <= 4'd0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      pbc_r         <= pbc_nxt;
      keyword_r     <= keyword_nxt;
      count_r       <= count_nxt;
      type_word_r   <= type_word_nxt;
      block_left_r  <= block_left_nxt;
      record_left_r <= record_left_nxt;
      elem_byte_r   <= elem_byte_nxt;
      elem_size_r   <= elem_size_nxt;
      cur_type_r    <= cur_type_nxt;
      acc_r         <= acc_nxt;
      fill_r        <= fill_nxt;
      out_valid_r   <= out_valid_nxt;
      skid_valid_r  <= skid_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      numeric_elems_r <= rbd_pkg::NUMERIC_ELEMS_RESET;
      text_elems_r    <= rbd_pkg::TEXT_ELEMS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rbd_pkg::CFG_NUMERIC_ELEMS: numeric_elems_r <= cfg_data;
        rbd_pkg::CFG_TEXT_ELEMS:    text_elems_r    <= cfg_data;
        default: begin
          numeric_elems_r <= numeric_elems_r;
        end
      endcase
    end
  end

  // The skid register is only ever filled behind a full output register.
  `RBD_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r)
  // Element chunks come only from the data phase.
  `RBD_ASSERT_SAME(a_chunk_in_data, res_valid && (res.kind == rbd_pkg::KIND_CHUNK), phase_r == PH_DATA)
  // A chunk never holds more than eight bytes.
  `RBD_ASSERT_SAME(a_fill_bound, phase_r == PH_DATA, fill_r < rbd_pkg::CHUNK_MAX)
  // The data phase always has elements left in the record and in the block.
  `RBD_ASSERT_SAME(a_data_left, phase_r == PH_DATA, (record_left_r != 10'd0) && (block_left_r != 32'd0))
  // The end of a file restarts at the lead marker.
  `RBD_ASSERT_NEXT(a_eof_restart, take_in && in_data.end_of_file, (phase_r == PH_LEAD) && (pbc_r == 5'd0))

endmodule

`default_nettype wire
